// File: rtl/iai_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iai_pkg
// Shared types, register codes and constants of the attitude integrator.
// ----------------------------------------------------------------------------
package iai_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int ANGLE_W = 32;
  localparam int CNT_W   = 5;
  localparam int ROT_STEPS = 10;

  localparam logic [CFG_IDX_W-1:0] REG_ROLL_OFF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_OFF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_OFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_OFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_STEP  = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Angles in 2^-16 degree.
  localparam int RED_W = 33;
  localparam logic [RED_W-1:0] FULL_TURN_R = 33'd23592960;
  // 92 full turns lift any 32-bit signed angle into positive range.
  localparam logic [RED_W-1:0] TURN_BIAS   = 33'd2170552320;
  localparam int RED_BITS = 8;

  localparam int Z_W = 26;
  localparam logic signed [Z_W-1:0] FULL_TURN_Z    = 26'sd23592960;
  localparam logic signed [Z_W-1:0] HALF_TURN_Z    = 26'sd11796480;
  localparam logic signed [Z_W-1:0] QUARTER_TURN_Z = 26'sd5898240;

  localparam int XY_W = 34;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032875;
  localparam int ROUND_HALF = 536870912;
  localparam int Q_SHIFT = 30;

  typedef struct packed {
    logic                  capture;
    logic                  gy_mul;
    logic                  gy_add;
    logic [1:0]            axis;
    logic                  red_load;
    logic                  red_step;
    logic                  fold;
    logic                  cord_step;
    logic                  sc_store;
    logic                  which;
    logic [CNT_W-1:0]      cnt;
    logic                  rot_en;
    logic                  out_load;
  } iai_cmd_t;

  typedef struct packed {
    logic out_busy;
  } iai_stat_t;

  // Arctangent of 2^-i in 2^-16 degree.
  function automatic logic [21:0] atan_deg16(input logic [CNT_W-1:0] i);
    logic [21:0] r;
    case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/imu_attitude_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_attitude_integrator
// Integrates gyro rates into roll, pitch and yaw and rotated vertical
// acceleration into a saturating vertical velocity.
// ----------------------------------------------------------------------------
// Usage:
// One sample is taken per request on the s_ channel; s_tuser selects gyro (0)
// or accelerometer (1). Every sample yields one request on the m_ channel
// carrying the four state values after the update.
// A gyro sample makes three passes of the shared multiplier, each followed by an angle add.
// An accelerometer sample runs, for roll and for pitch, an angle reduction and one CORDIC
// iteration per cycle, then ten multiply and accumulate steps.
// s_tready is high only while idle, so no new sample is taken before the last is through.
// Reset clears angles, velocity and all configuration registers to zero.
// The result sits in an output register; the next sample is taken while it
// waits. If m_tready stays low, the following result holds in the sequencer.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must do
// so only while idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module imu_attitude_integrator #(
  parameter int CORDIC_STEPS = iai_pkg::CORDIC_STEPS_DEF,
  parameter int SAMPLE_WIDTH = iai_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [iai_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [iai_pkg::CFG_W-1:0]                cfg_data,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // x_sample, y_sample, z_sample, zero padding
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,
  // command
  input  logic                                     s_tuser,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // roll_out, pitch_out, yaw_out, vertical_velocity_out
  output logic [4*iai_pkg::ANGLE_W-1:0]            m_tdata
);
  import iai_pkg::*;

  localparam int IN_W = ((3 * SAMPLE_WIDTH + 7) / 8) * 8;

  iai_cmd_t  cmd;
  iai_stat_t stat;

  iai_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  iai_datapath #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .IN_W        (IN_W)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

// File: rtl/iai_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iai_ctrl
// Sequencer for the gyro update, angle reduction, CORDIC and rotation steps.
// ----------------------------------------------------------------------------
module iai_ctrl #(
  parameter int CORDIC_STEPS = iai_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_ready,
  input  iai_pkg::iai_stat_t stat,
  output iai_pkg::iai_cmd_t  cmd
);
  import iai_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GMUL  = 4'd1;
  localparam logic [3:0] S_GADD  = 4'd2;
  localparam logic [3:0] S_RLOAD = 4'd3;
  localparam logic [3:0] S_RRED  = 4'd4;
  localparam logic [3:0] S_FOLD  = 4'd5;
  localparam logic [3:0] S_CORD  = 4'd6;
  localparam logic [3:0] S_SCST  = 4'd7;
  localparam logic [3:0] S_ROT   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [CNT_W-1:0] RED_LAST  = CNT_W'(RED_BITS - 1);
  localparam logic [CNT_W-1:0] ROT_LAST  = CNT_W'(ROT_STEPS - 1);

  logic [3:0]       state, state_next;
  logic [1:0]       axis, axis_next;
  logic             which, which_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= AXIS_X;
      which <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      which <= which_next;
      cnt   <= cnt_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    axis_next  = axis;
    which_next = which;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.axis   = axis;
    cmd.which  = which;
    cmd.cnt    = cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          axis_next   = AXIS_X;
          which_next  = 1'b0;
          state_next  = in_kind ? S_RLOAD : S_GMUL;
        end
      end
      S_GMUL: begin
        cmd.gy_mul = 1'b1;
        state_next = S_GADD;
      end
      S_GADD: begin
        cmd.gy_add = 1'b1;
        if (axis == AXIS_Z) begin
          state_next = S_OUT;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = S_GMUL;
        end
      end
      S_RLOAD: begin
        cmd.red_load = 1'b1;
        cnt_next     = RED_LAST;
        state_next   = S_RRED;
      end
      S_RRED: begin
        cmd.red_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_FOLD;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_FOLD: begin
        cmd.fold   = 1'b1;
        cnt_next   = '0;
        state_next = S_CORD;
      end
      S_CORD: begin
        cmd.cord_step = 1'b1;
        if (cnt == CORD_LAST) begin
          state_next = S_SCST;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_SCST: begin
        cmd.sc_store = 1'b1;
        if (!which) begin
          which_next = 1'b1;
          state_next = S_RLOAD;
        end else begin
          cnt_next   = '0;
          state_next = S_ROT;
        end
      end
      S_ROT: begin
        cmd.rot_en = 1'b1;
        if (cnt == ROT_LAST) begin
          state_next = S_OUT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_cord_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_CORD |-> cnt <= CORD_LAST)
    else $error("CORDIC step counter out of range");
  a_red_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_RRED |-> cnt <= RED_LAST)
    else $error("reduction counter out of range");
  a_out_leave: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && !stat.out_busy |=> state == S_IDLE)
    else $error("result not handed over");
  a_gyro_axis: assert property (@(posedge clk) disable iff (rst)
    state == S_GADD |-> axis != 2'd3)
    else $error("gyro axis out of range");
`endif

endmodule

// File: rtl/iai_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iai_datapath
// Configuration, state registers, angle reduction, CORDIC, shared multiplier.
// ----------------------------------------------------------------------------
module iai_datapath #(
  parameter int SAMPLE_WIDTH = iai_pkg::SAMPLE_WIDTH_DEF,
  parameter int IN_W = ((3 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [iai_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [iai_pkg::CFG_W-1:0]       cfg_data,
  input  logic [IN_W-1:0]                 in_data,
  input  iai_pkg::iai_cmd_t               cmd,
  output iai_pkg::iai_stat_t              stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [4*iai_pkg::ANGLE_W-1:0]   out_data
);
  import iai_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int MA_W = ((SW > CFG_W) ? SW : CFG_W) + 4;
  localparam int MB_W = XY_W;
  localparam int PW   = MA_W + MB_W;
  localparam int ACC_W = PW + 2;

  logic signed [CFG_W-1:0] roll_off, pitch_off, yaw_off, vert_off;
  logic [CFG_W-1:0]        gyro_step, accel_step;
  logic signed [SW-1:0]    xs, ys, zs;
  logic [ANGLE_W-1:0]      roll, pitch, yaw, vel;

  logic [RED_W-1:0]        red;
  logic signed [XY_W-1:0]  cx, cy, sr, cr, sp, cp;
  logic signed [Z_W-1:0]   cz;
  logic                    neg_cos;

  logic signed [MA_W-1:0]  ma, rot;
  logic signed [MB_W-1:0]  mb;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc, rsum;
  logic                    mul_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      roll_off   <= '0;
      pitch_off  <= '0;
      yaw_off    <= '0;
      vert_off   <= '0;
      gyro_step  <= '0;
      accel_step <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROLL_OFF:  roll_off   <= cfg_data;
        REG_PITCH_OFF: pitch_off  <= cfg_data;
        REG_YAW_OFF:   yaw_off    <= cfg_data;
        REG_VERT_OFF:  vert_off   <= cfg_data;
        REG_GYRO_STEP: gyro_step  <= cfg_data;
        REG_ACC_STEP:  accel_step <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      xs <= in_data[SW-1:0];
      ys <= in_data[2*SW-1:SW];
      zs <= in_data[3*SW-1:2*SW];
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    ma     = '0;
    mb     = '0;
    mul_en = 1'b0;
    if (cmd.gy_mul) begin
      mul_en = 1'b1;
      mb     = MB_W'($signed({1'b0, gyro_step}));
      case (cmd.axis)
        AXIS_X:  ma = MA_W'(xs) - MA_W'(roll_off);
        AXIS_Y:  ma = MA_W'(ys) - MA_W'(pitch_off);
        default: ma = MA_W'(zs) - MA_W'(yaw_off);
      endcase
    end else if (cmd.rot_en) begin
      case (cmd.cnt)
        5'd0: begin mul_en = 1'b1; ma = MA_W'(ys); mb = sr; end
        5'd1: begin mul_en = 1'b1; ma = MA_W'(zs); mb = cr; end
        5'd4: begin mul_en = 1'b1; ma = MA_W'(xs); mb = sp; end
        5'd5: begin mul_en = 1'b1; ma = rot; mb = cp; end
        5'd8: begin
          mul_en = 1'b1;
          ma = rot - MA_W'(vert_off);
          mb = MB_W'($signed({1'b0, accel_step}));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= ma * mb;
    end
  end

  assign rsum = acc + ACC_W'(ROUND_HALF);

  logic signed [PW:0] vsum;
  logic signed [PW:0] vmax;
  assign vsum = (PW+1)'($signed(vel)) + (PW+1)'(prod);
  assign vmax = $signed({{(PW+1-31){1'b0}}, {31{1'b1}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      roll  <= '0;
      pitch <= '0;
      yaw   <= '0;
      vel   <= '0;
    end else if (cmd.gy_add) begin
      case (cmd.axis)
        AXIS_X:  roll  <= roll + prod[ANGLE_W-1:0];
        AXIS_Y:  pitch <= pitch + prod[ANGLE_W-1:0];
        default: yaw   <= yaw + prod[ANGLE_W-1:0];
      endcase
    end else if (cmd.rot_en && cmd.cnt == 5'd9) begin
      if (vsum > vmax) begin
        vel <= vmax[ANGLE_W-1:0];
      end else if (vsum < ~vmax) begin
        vel <= ~vmax[ANGLE_W-1:0];
      end else begin
        vel <= vsum[ANGLE_W-1:0];
      end
    end
  end

  // Rotation accumulate and round steps.
  always_ff @(posedge clk) begin
    if (cmd.rot_en) begin
      case (cmd.cnt)
        5'd1: acc <= ACC_W'(prod);
        5'd2: acc <= acc + ACC_W'(prod);
        5'd3: rot <= MA_W'(rsum >>> Q_SHIFT);
        5'd5: acc <= -ACC_W'(prod);
        5'd6: acc <= acc + ACC_W'(prod);
        5'd7: rot <= MA_W'(rsum >>> Q_SHIFT);
        default: ;
      endcase
    end
  end

  // Angle reduction to [0, 360) by restoring subtraction, one bit a cycle.
  logic [RED_W-1:0]       thr;
  logic [ANGLE_W-1:0]     ang_sel;
  logic signed [Z_W-1:0]  a_wrap, a_fold;
  logic                   a_neg;
  assign thr     = FULL_TURN_R << cmd.cnt[2:0];
  assign ang_sel = cmd.which ? pitch : roll;

  always_comb begin
    a_wrap = (red >= RED_W'(HALF_TURN_Z)) ? Z_W'(red) - FULL_TURN_Z : Z_W'(red);
    a_fold = a_wrap;
    a_neg  = 1'b0;
    if (a_wrap > QUARTER_TURN_Z) begin
      a_fold = HALF_TURN_Z - a_wrap;
      a_neg  = 1'b1;
    end else if (a_wrap < -QUARTER_TURN_Z) begin
      a_fold = -HALF_TURN_Z - a_wrap;
      a_neg  = 1'b1;
    end
  end

  logic signed [Z_W-1:0] atan_z;
  assign atan_z = Z_W'(atan_deg16(cmd.cnt));

  always_ff @(posedge clk) begin
    if (cmd.red_load) begin
      red <= {ang_sel[ANGLE_W-1], ang_sel} + TURN_BIAS;
    end else if (cmd.red_step && red >= thr) begin
      red <= red - thr;
    end
    if (cmd.fold) begin
      cx      <= GAIN_Q30;
      cy      <= '0;
      cz      <= a_fold;
      neg_cos <= a_neg;
    end else if (cmd.cord_step) begin
      if (!cz[Z_W-1]) begin
        cx <= cx - (cy >>> cmd.cnt);
        cy <= cy + (cx >>> cmd.cnt);
        cz <= cz - atan_z;
      end else begin
        cx <= cx + (cy >>> cmd.cnt);
        cy <= cy - (cx >>> cmd.cnt);
        cz <= cz + atan_z;
      end
    end
    if (cmd.sc_store) begin
      if (!cmd.which) begin
        sr <= cy;
        cr <= neg_cos ? -cx : cx;
      end else begin
        sp <= cy;
        cp <= neg_cos ? -cx : cx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {vel, yaw, pitch, roll};
    end
  end

  assign stat.out_busy = out_valid & ~out_ready;

endmodule
